>>> rtl/bdm_pkg.sv
// Shared types and constants for the 5x5 Bayer demosaic block.
// No dependencies; imported by every module of the block except bdm_ram.
`timescale 1ns / 1ps

package bdm_pkg;

   // Sample and window geometry
   localparam int PIX_W     = 8;
   localparam int NUM_LINES = 4;
   localparam int WIN       = 5;
   localparam int ROW_W     = 10;
   localparam int SUM_W     = 14;

   // Configuration port
   localparam int WIDTH_CFG_W = 11;
   localparam int SHIFT_W     = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_SHIFT = 1'b1;

   localparam logic [WIDTH_CFG_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [SHIFT_W-1:0]     OUTPUT_SHIFT_RESET = 4'd4;

   // Queue between front and back, and items the whole pipeline can hold
   localparam int QUEUE_DEPTH   = 2;
   localparam int PIPE_CAPACITY = QUEUE_DEPTH + 3;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [WIN-1:0][WIN-1:0] window_type;   // [row][column]
   typedef logic [SUM_W-1:0] sum_type;

   // Color phase of the newest sample: {row odd, column odd}
   typedef enum logic [1:0] {
      PHASE_B  = 2'b00,
      PHASE_GB = 2'b01,
      PHASE_GR = 2'b10,
      PHASE_R  = 2'b11
   } phase_type;

   // One classified pixel handed from front to back
   typedef struct packed {
      logic       line_end;
      phase_type  phase;
      window_type pix;
   } patch_type;

endpackage

>>> rtl/bdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write. No dependencies.
`timescale 1ns / 1ps

module bdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bdm_front.sv
// Front end: accepts raw samples, tracks row and column, keeps the line stores
// and the 5x5 window, and hands masked windows to the queue. Uses bdm_pkg, bdm_ram.
`timescale 1ns / 1ps

module bdm_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bdm_pkg::PIX_W-1:0]          req_raw_pixel,
   input  logic                               req_frame_start,
   input  logic [bdm_pkg::WIDTH_CFG_W-1:0]    image_width,
   output logic                               push_valid,
   input  logic                               push_ready,
   output bdm_pkg::patch_type                 push_data
);

   import bdm_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = CW + 1;
   localparam int CMP_W = (WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W;
   localparam int LS_W  = NUM_LINES * PIX_W;

   typedef logic [NUM_LINES-1:0][PIX_W-1:0] lines_type;

   // Position counters
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] cur_row;
   logic [CW-1:0]    cur_col;
   logic [CMP_W-1:0] width_ext, width_eff, col_next_ext;
   logic             cur_last;

   // Stage holding the sample while its line-store read completes
   logic             s1_valid_ff, s1_valid_in;
   pix_type          s1_pix_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [CW-1:0]    s1_col_ff;
   logic             s1_last_ff;

   // Most recent line-store write, forwarded to a read of the same column
   logic             byp_valid_ff;
   logic [CW-1:0]    byp_addr_ff;
   lines_type        byp_data_ff;

   logic             accept, advance;
   logic [LS_W-1:0]  ram_rd_data;
   lines_type        line_cur, line_new;
   pix_type [WIN-1:0] vcol;
   window_type       window_ff, window_shift;
   logic [WIN-1:0]   row_ok, col_ok;

   assign accept    = req_valid && !req_stall;
   assign advance   = s1_valid_ff && push_ready;
   assign req_stall = reset || (s1_valid_ff && !push_ready);

   // Clamp the configured width to 1..MAX_WIDTH
   assign width_ext = CMP_W'(image_width);
   always_comb begin
      if (width_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
   end

   // Position of the incoming sample; a frame start restarts at the origin
   assign cur_row      = req_frame_start ? '0 : row_ff;
   assign cur_col      = req_frame_start ? '0 : col_ff;
   assign col_next_ext = CMP_W'(cur_col) + CMP_W'(1);
   assign cur_last     = (col_next_ext >= width_eff);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (cur_last) begin
            col_in = '0;
            row_in = cur_row + ROW_W'(1);
         end else begin
            col_in = CW'(col_next_ext);
            row_in = cur_row;
         end
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            byp_valid_ff <= 1'b1;
         end
      end
   end

   // Capture the accepted sample; record the write and shift the window on advance
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_raw_pixel;
         s1_row_ff  <= cur_row;
         s1_col_ff  <= cur_col;
         s1_last_ff <= cur_last;
      end
      if (advance) begin
         byp_addr_ff <= s1_col_ff;
         byp_data_ff <= line_new;
         window_ff   <= window_shift;
      end
   end

   // Four line stores side by side: one word per column, newest line in the low byte
   bdm_ram #(
      .WIDTH (LS_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_col_ff),
      .wr_data (line_new),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (ram_rd_data)
   );

   assign line_cur = (byp_valid_ff && (byp_addr_ff == s1_col_ff)) ? byp_data_ff
                                                                  : ram_rd_data;
   assign line_new = {line_cur[NUM_LINES-2:0], s1_pix_ff};

   // Vertical column, oldest row on top
   always_comb begin
      for (int y = 0; y < NUM_LINES; y++) begin
         vcol[y] = line_cur[NUM_LINES-1-y];
      end
      vcol[WIN-1] = s1_pix_ff;
   end

   // Shift the window left and bring in the new column
   always_comb begin
      for (int y = 0; y < WIN; y++) begin
         for (int x = 0; x < WIN-1; x++) begin
            window_shift[y][x] = window_ff[y][x+1];
         end
         window_shift[y][WIN-1] = vcol[y];
      end
   end

   // Zero the samples that fall above or left of the frame
   always_comb begin
      for (int k = 0; k < WIN; k++) begin
         row_ok[k] = (s1_row_ff >= ROW_W'(WIN-1-k));
         col_ok[k] = (s1_col_ff >= CW'(WIN-1-k));
      end
      for (int y = 0; y < WIN; y++) begin
         for (int x = 0; x < WIN; x++) begin
            push_data.pix[y][x] = (row_ok[y] && col_ok[x]) ? window_shift[y][x] : '0;
         end
      end
      push_data.phase    = phase_type'({s1_row_ff[0], s1_col_ff[0]});
      push_data.line_end = s1_last_ff;
   end

   assign push_valid = s1_valid_ff;

endmodule

>>> rtl/bdm_queue.sv
// Short queue of classified windows between front and back end.
// Depth from bdm_pkg::QUEUE_DEPTH. Uses bdm_pkg.
`timescale 1ns / 1ps

module bdm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  bdm_pkg::patch_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output bdm_pkg::patch_type pop_data
);

   import bdm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   patch_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/bdm_back.sv
// Back end: applies the phase-dependent 5x5 kernels, then shifts, saturates
// and presents the RGB result. Uses bdm_pkg.
`timescale 1ns / 1ps

module bdm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  bdm_pkg::patch_type            pop_data,
   input  logic [bdm_pkg::SHIFT_W-1:0]   output_shift,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bdm_pkg::PIX_W-1:0]     rsp_blue,
   output logic [bdm_pkg::PIX_W-1:0]     rsp_green,
   output logic [bdm_pkg::PIX_W-1:0]     rsp_red,
   output logic                          rsp_line_end
);

   import bdm_pkg::*;

   // Kernel weights (each kernel sums to 64)
   localparam sum_type W2  = SUM_W'(2);
   localparam sum_type W4  = SUM_W'(4);
   localparam sum_type W6  = SUM_W'(6);
   localparam sum_type W8  = SUM_W'(8);
   localparam sum_type W14 = SUM_W'(14);
   localparam sum_type W16 = SUM_W'(16);
   localparam sum_type W24 = SUM_W'(24);
   localparam sum_type W36 = SUM_W'(36);
   localparam sum_type SAT_MAX = SUM_W'(255);

   function automatic sum_type ext(input pix_type v);
      return SUM_W'(v);
   endfunction

   function automatic pix_type saturate(input sum_type s, input logic [SHIFT_W-1:0] sh);
      sum_type v;
      v = s >> sh;
      return (v > SAT_MAX) ? PIX_W'(SAT_MAX) : v[PIX_W-1:0];
   endfunction

   window_type p;
   sum_type    edge4, cross4;
   sum_type    k_diag, k_green1, k_x, k_green2, k_horz, k_vert;
   sum_type    blue_sum, green_sum, red_sum;

   logic       sum_valid_ff, sum_valid_in;
   sum_type    blue_sum_ff, green_sum_ff, red_sum_ff;
   logic       sum_last_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   pix_type    rsp_blue_ff, rsp_green_ff, rsp_red_ff;
   logic       rsp_last_ff;

   logic       out_ready, pop;

   // Kernels shared by the four phases
   assign p      = pop_data.pix;
   assign edge4  = ext(p[0][2]) + ext(p[2][0]) + ext(p[2][4]) + ext(p[4][2]);
   assign cross4 = ext(p[1][1]) + ext(p[1][3]) + ext(p[3][1]) + ext(p[3][3]);

   assign k_diag   = ext(p[0][0]) + ext(p[0][4]) + ext(p[4][0]) + ext(p[4][4])
                   + W6 * edge4 + W36 * ext(p[2][2]);
   assign k_green1 = ext(p[0][1]) + ext(p[0][3]) + ext(p[1][0]) + ext(p[1][4])
                   + ext(p[3][0]) + ext(p[3][4]) + ext(p[4][1]) + ext(p[4][3])
                   + W14 * (ext(p[1][2]) + ext(p[2][1]) + ext(p[2][3]) + ext(p[3][2]));
   assign k_x      = W16 * cross4;
   assign k_green2 = W2 * edge4 + W8 * cross4 + W24 * ext(p[2][2]);
   assign k_horz   = W4 * (ext(p[0][1]) + ext(p[0][3]) + ext(p[4][1]) + ext(p[4][3]))
                   + W24 * (ext(p[2][1]) + ext(p[2][3]));
   assign k_vert   = W4 * (ext(p[1][0]) + ext(p[1][4]) + ext(p[3][0]) + ext(p[3][4]))
                   + W24 * (ext(p[1][2]) + ext(p[3][2]));

   // Route kernels to channels by color phase
   always_comb begin
      case (pop_data.phase)
         PHASE_B: begin
            blue_sum  = k_diag;
            green_sum = k_green1;
            red_sum   = k_x;
         end
         PHASE_GB: begin
            blue_sum  = k_horz;
            green_sum = k_green2;
            red_sum   = k_vert;
         end
         PHASE_GR: begin
            blue_sum  = k_vert;
            green_sum = k_green2;
            red_sum   = k_horz;
         end
         PHASE_R: begin
            blue_sum  = k_x;
            green_sum = k_green1;
            red_sum   = k_diag;
         end
         default: begin
            blue_sum  = '0;
            green_sum = '0;
            red_sum   = '0;
         end
      endcase
   end

   // Pipeline flow control: the output register parts the sum stage from the receiver
   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign pop_ready    = !sum_valid_ff || out_ready;
   assign pop          = pop_valid && pop_ready;
   assign sum_valid_in = pop ? 1'b1 : (out_ready ? 1'b0 : sum_valid_ff);
   assign rsp_valid_in = out_ready ? sum_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold sums, then shift and saturate into the output register
   always_ff @(posedge clock) begin
      if (pop) begin
         blue_sum_ff  <= blue_sum;
         green_sum_ff <= green_sum;
         red_sum_ff   <= red_sum;
         sum_last_ff  <= pop_data.line_end;
      end
      if (out_ready && sum_valid_ff) begin
         rsp_blue_ff  <= saturate(blue_sum_ff, output_shift);
         rsp_green_ff <= saturate(green_sum_ff, output_shift);
         rsp_red_ff   <= saturate(red_sum_ff, output_shift);
         rsp_last_ff  <= sum_last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_blue     = rsp_blue_ff;
   assign rsp_green    = rsp_green_ff;
   assign rsp_red      = rsp_red_ff;
   assign rsp_line_end = rsp_last_ff;

endmodule

>>> rtl/bayer_demosaic_5x5.sv
// Streaming 5x5 Bayer demosaic, raw 8-bit samples in, RGB24 out.
// Input channel req_*: one raw sample per transaction in row-major order;
// req_frame_start marks row 0, column 0 of a frame. Result channel rsp_*: one
// RGB pixel per input sample, in order, with rsp_line_end on the last column.
// The result belongs to the 5x5 window whose bottom-right sample is the input;
// samples above or left of the frame count as zero. Blue sits at even row and
// even column.
// Configuration (csr_*): index 0 image width (clamped to 1..MAX_WIDTH), index 1
// right shift of each channel sum before saturation at 255. Write only while idle.
// Throughput: one transaction per cycle in both directions while the receiver
// does not stall, limited by the single read-modify-write of the packed line store,
// one column per cycle. Path of a result: line-store read stage, queue, kernel sum
// register, then shift/saturate into the output register.
// Reset clears position and pipeline control; req_stall is high during reset.
// Line stores need no clearing. When the receiver stalls, the result holds,
// the back end and queue fill, and req_stall rises once the front cannot advance.
// Uses bdm_pkg, bdm_front, bdm_queue, bdm_back.
`timescale 1ns / 1ps

module bayer_demosaic_5x5 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bdm_pkg::PIX_W-1:0]         req_raw_pixel,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bdm_pkg::PIX_W-1:0]         rsp_blue,
   output logic [bdm_pkg::PIX_W-1:0]         rsp_green,
   output logic [bdm_pkg::PIX_W-1:0]         rsp_red,
   output logic                              rsp_line_end,
   input  logic                              csr_write_en,
   input  logic [bdm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import bdm_pkg::*;

   logic [WIDTH_CFG_W-1:0] image_width_ff;
   logic [SHIFT_W-1:0]     output_shift_ff;

   patch_type push_data, pop_data;
   logic      push_valid, push_ready, pop_valid, pop_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         output_shift_ff <= OUTPUT_SHIFT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[WIDTH_CFG_W-1:0];
            CSR_OUTPUT_SHIFT: output_shift_ff <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   bdm_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_pixel   (req_raw_pixel),
      .req_frame_start (req_frame_start),
      .image_width     (image_width_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   bdm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bdm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .output_shift (output_shift_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_blue     (rsp_blue),
      .rsp_green    (rsp_green),
      .rsp_red      (rsp_red),
      .rsp_line_end (rsp_line_end)
   );

endmodule

>>> rtl/bdm_checker.sv
// Port-level checks for bayer_demosaic_5x5, bound to the top level.
// Uses bdm_pkg.
`timescale 1ns / 1ps

module bdm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [bdm_pkg::PIX_W-1:0] rsp_blue,
   input logic [bdm_pkg::PIX_W-1:0] rsp_green,
   input logic [bdm_pkg::PIX_W-1:0] rsp_red,
   input logic                      rsp_line_end
);

   import bdm_pkg::*;

   localparam int CNT_W = $clog2(PIPE_CAPACITY + 1);

   logic [CNT_W-1:0] outstanding_ff, outstanding_in;
   logic             in_xfer, out_xfer;

   assign in_xfer  = req_valid && !req_stall;
   assign out_xfer = rsp_valid && !rsp_stall;

   // Count transactions accepted but not yet delivered
   always_comb begin
      outstanding_in = outstanding_ff;
      if (in_xfer && !out_xfer) begin
         outstanding_in = outstanding_ff + CNT_W'(1);
      end else if (out_xfer && !in_xfer) begin
         outstanding_in = outstanding_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_blue) && $stable(rsp_green)
                                 && $stable(rsp_red) && $stable(rsp_line_end))
      else $error("stalled result changed or dropped");

   a_reset_stall: assert property (@(posedge clock)
      reset |-> req_stall)
      else $error("input not stalled during reset");

   a_reset_latency: assert property (@(posedge clock)
      !reset && ($past(reset) || $past(reset, 2) || $past(reset, 3) || $past(reset, 4))
      |-> !rsp_valid)
      else $error("result appeared sooner than the pipeline allows after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("result without an accepted input");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= CNT_W'(PIPE_CAPACITY))
      else $error("more transactions in flight than the pipeline holds");

endmodule

bind bayer_demosaic_5x5 bdm_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_blue     (rsp_blue),
   .rsp_green    (rsp_green),
   .rsp_red      (rsp_red),
   .rsp_line_end (rsp_line_end)
);

>>> tb/bayer_demosaic_5x5_checker.sv
// Scoreboard for the 5x5 Bayer demosaic: watches the pixel, result and register ports,
// predicts every RGB result from its own copy of the line stores and window, and compares.
// Depends on bdm_pkg for widths, register indexes and color phases.
`timescale 1ns / 1ps

module bayer_demosaic_5x5_checker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [bdm_pkg::PIX_W-1:0]       req_raw_pixel,
   input  logic                            req_frame_start,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [bdm_pkg::PIX_W-1:0]       rsp_blue,
   input  logic [bdm_pkg::PIX_W-1:0]       rsp_green,
   input  logic [bdm_pkg::PIX_W-1:0]       rsp_red,
   input  logic                            rsp_line_end,
   input  logic                            csr_write_en,
   input  logic [bdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bdm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              pending,
   output int                              failures
);
   import bdm_pkg::*;

   localparam int PIX_MAX      = (1 << PIX_W) - 1;
   localparam int BORDER       = WIN - 1;

   typedef struct packed {
      pix_type blue;
      pix_type green;
      pix_type red;
      logic    line_end;
   } rgb_pixel_type;

   // Model state: line stores, sliding window, raster position and registers
   pix_type                line_mem [NUM_LINES][MAX_WIDTH];
   pix_type                win_taps [WIN][WIN];
   int unsigned            taps     [WIN][WIN];
   logic [ROW_W-1:0]       row_pos;
   int unsigned            col_pos;
   logic [WIDTH_CFG_W-1:0] width_reg;
   logic [SHIFT_W-1:0]     shift_reg;
   rgb_pixel_type          expected_pixels [$];

   initial begin
      pending  = 0;
      failures = 0;
   end

   // Same-color kernel: center sample plus the eight samples two steps away
   function automatic int unsigned corner_sum();
      return taps[0][0] + 6 * taps[0][2] + taps[0][4] + 6 * taps[2][0] + 36 * taps[2][2]
           + 6 * taps[2][4] + taps[4][0] + 6 * taps[4][2] + taps[4][4];
   endfunction

   // Green at a blue or red site
   function automatic int unsigned cross_sum();
      return taps[0][1] + taps[0][3] + taps[1][0] + 14 * taps[1][2] + taps[1][4]
           + 14 * (taps[2][1] + taps[2][3]) + taps[3][0] + 14 * taps[3][2] + taps[3][4]
           + taps[4][1] + taps[4][3];
   endfunction

   // Opposite color on the diagonals
   function automatic int unsigned diag_sum();
      return 16 * (taps[1][1] + taps[1][3] + taps[3][1] + taps[3][3]);
   endfunction

   // Color found left and right of a green site
   function automatic int unsigned row_pair_sum();
      return 4 * (taps[0][1] + taps[0][3]) + 24 * (taps[2][1] + taps[2][3])
           + 4 * (taps[4][1] + taps[4][3]);
   endfunction

   // Color found above and below a green site
   function automatic int unsigned col_pair_sum();
      return 4 * taps[1][0] + 24 * taps[1][2] + 4 * taps[1][4]
           + 4 * taps[3][0] + 24 * taps[3][2] + 4 * taps[3][4];
   endfunction

   // Green at a green site
   function automatic int unsigned green_sum();
      return 2 * taps[0][2] + 8 * (taps[1][1] + taps[1][3]) + 2 * taps[2][0]
           + 24 * taps[2][2] + 2 * taps[2][4] + 8 * (taps[3][1] + taps[3][3])
           + 2 * taps[4][2];
   endfunction

   function automatic pix_type clip_channel(input int unsigned sum);
      int unsigned v;
      v = sum >> shift_reg;
      return (v > PIX_MAX) ? pix_type'(PIX_MAX) : pix_type'(v);
   endfunction

   // Advance the model by one raw sample and return the RGB pixel it yields
   function automatic rgb_pixel_type demosaic_step(input pix_type pix, input logic first);
      int unsigned   eff_w;
      int unsigned   r;
      int unsigned   c;
      int unsigned   b_sum;
      int unsigned   g_sum;
      int unsigned   r_sum;
      int            x;
      int            y;
      pix_type       column [WIN];
      rgb_pixel_type res;

      eff_w = 32'(width_reg);
      if (eff_w < 1) eff_w = 1;
      if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
      if (first) begin
         row_pos = '0;
         col_pos = 0;
      end
      r = 32'(row_pos);
      c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;

      // read the column above, oldest line first, then shift the new sample in
      for (y = 0; y < NUM_LINES; y++)
         column[y] = line_mem[NUM_LINES - 1 - y][c];
      column[WIN - 1] = pix;
      for (y = NUM_LINES - 1; y > 0; y--)
         line_mem[y][c] = line_mem[y - 1][c];
      line_mem[0][c] = pix;

      // slide the window left and zero whatever lies above or left of the frame
      for (y = 0; y < WIN; y++) begin
         for (x = 0; x < WIN - 1; x++)
            win_taps[y][x] = win_taps[y][x + 1];
         win_taps[y][WIN - 1] = column[y];
      end
      for (y = 0; y < WIN; y++)
         for (x = 0; x < WIN; x++)
            taps[y][x] = (r + y < BORDER || c + x < BORDER) ? 0 : 32'(win_taps[y][x]);

      case (phase_type'({r[0], c[0]}))
         PHASE_B: begin
            b_sum = corner_sum();
            g_sum = cross_sum();
            r_sum = diag_sum();
         end
         PHASE_GB: begin
            b_sum = row_pair_sum();
            g_sum = green_sum();
            r_sum = col_pair_sum();
         end
         PHASE_GR: begin
            b_sum = col_pair_sum();
            g_sum = green_sum();
            r_sum = row_pair_sum();
         end
         default: begin
            b_sum = diag_sum();
            g_sum = cross_sum();
            r_sum = corner_sum();
         end
      endcase

      // end the row on the last column, or at once if the width shrank under us
      res.line_end = (c + 1 >= eff_w);
      if (res.line_end) begin
         col_pos = 0;
         row_pos = row_pos + ROW_W'(1);
      end else begin
         col_pos = c + 1;
      end

      res.blue  = clip_channel(b_sum);
      res.green = clip_channel(g_sum);
      res.red   = clip_channel(r_sum);
      return res;
   endfunction

   task automatic check_field(input string field, input pix_type want, input pix_type got);
      if (got !== want) begin
         failures++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field, want, got);
      end
   endtask

   // Watch every channel at the rising edge
   always @(posedge clock) begin
      rgb_pixel_type want;
      int            y;
      int            x;
      if (reset) begin
         for (y = 0; y < NUM_LINES; y++)
            for (x = 0; x < MAX_WIDTH; x++)
               line_mem[y][x] = '0;
         for (y = 0; y < WIN; y++)
            for (x = 0; x < WIN; x++)
               win_taps[y][x] = '0;
         row_pos   = '0;
         col_pos   = 0;
         width_reg = IMAGE_WIDTH_RESET;
         shift_reg = OUTPUT_SHIFT_RESET;
         expected_pixels.delete();
      end else begin
         // compare the returned transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               failures++;
               $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                        $time, rsp_blue, rsp_green, rsp_red, rsp_line_end);
            end else begin
               want = expected_pixels.pop_front();
               check_field("blue", want.blue, rsp_blue);
               check_field("green", want.green, rsp_green);
               check_field("red", want.red, rsp_red);
               check_field("line_end", pix_type'(want.line_end), pix_type'(rsp_line_end));
            end
         end
         // track register writes
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg = csr_wdata[WIDTH_CFG_W-1:0];
               CSR_OUTPUT_SHIFT: shift_reg = csr_wdata[SHIFT_W-1:0];
               default:          ;
            endcase
         end
         // predict the accepted sample
         if (req_valid && !req_stall)
            expected_pixels.push_back(demosaic_step(req_raw_pixel, req_frame_start));
      end
      pending = expected_pixels.size();
   end

endmodule

>>> tb/bayer_demosaic_5x5_test.sv
// Top of the 5x5 Bayer demosaic testbench: clock, reset, pixel stimulus, result stalls
// and register phases; the verdict comes from bayer_demosaic_5x5_checker.
// Depends on bdm_pkg, bayer_demosaic_5x5 and bayer_demosaic_5x5_checker.
`timescale 1ns / 1ps

module bayer_demosaic_5x5_test;
   import bdm_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int RANDOM_PIXELS = 1250;
   localparam int PHASE_CAP     = 400;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 10;
   localparam int WIDTH_ALL     = (1 << WIDTH_CFG_W) - 1;
   localparam int SHIFT_ALL     = (1 << SHIFT_W) - 1;

   typedef enum int {
      FILL_RANDOM,
      FILL_EXTREME,
      FILL_BRIGHT,
      FILL_DIM
   } fill_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   pix_type                req_raw_pixel;
   logic                   req_frame_start;
   logic                   rsp_valid;
   logic                   rsp_stall;
   pix_type                rsp_blue;
   logic [PIX_W-1:0]       rsp_green;
   logic [PIX_W-1:0]       rsp_red;
   logic                   rsp_line_end;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     pending;
   int                     failures;

   bit hold_output = 1'b0;
   bit in_idle_on  = 1'b0;
   bit out_idle_on = 1'b0;
   int frame_width;   // narrowest effective width since the current frame began

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bayer_demosaic_5x5 #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_raw_pixel, .req_frame_start,
      .rsp_valid, .rsp_stall, .rsp_blue, .rsp_green, .rsp_red, .rsp_line_end,
      .csr_write_en, .csr_index, .csr_wdata
   );

   bayer_demosaic_5x5_checker #(.MAX_WIDTH(MAX_WIDTH)) scoreboard (
      .clock, .reset,
      .req_valid, .req_stall, .req_raw_pixel, .req_frame_start,
      .rsp_valid, .rsp_stall, .rsp_blue, .rsp_green, .rsp_red, .rsp_line_end,
      .csr_write_en, .csr_index, .csr_wdata,
      .pending, .failures
   );

   // Mostly no gap, often a short one, now and then a long one
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Offer one sample and hold it until the block takes it
   task automatic send_pixel(input pix_type pix, input logic fs);
      req_valid       <= 1'b1;
      req_raw_pixel   <= pix;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic pause_input(input int n);
      if (n > 0) begin
         req_valid       <= 1'b0;
         req_raw_pixel   <= pix_type'($urandom);
         req_frame_start <= 1'($urandom);
         repeat (n) @(negedge clock);
      end
   endtask

   // Hold off until every predicted result has come back, then let the pipe settle
   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      csr_wdata    <= CSR_DATA_W'($urandom);
      @(negedge clock);
   endtask

   task automatic program_setting(input int width, input int shift);
      logic [CSR_DATA_W-1:0] data;
      wait_drained();
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(width));
      // junk in the unused upper bits of the shift register write
      data = CSR_DATA_W'($urandom);
      data[SHIFT_W-1:0] = SHIFT_W'(shift);
      write_csr(CSR_OUTPUT_SHIFT, data);
   endtask

   // Stream one phase of samples; a frame restart may be forced on the first one
   task automatic run_phase(input int count, input int eff, input fill_mode_type mode,
                            input bit start_frame, input bit noise);
      int      i;
      pix_type pix;
      logic    fs;
      for (i = 0; i < count; i++) begin
         case (mode)
            FILL_EXTREME: pix = $urandom_range(0, 1) ? '1 : '0;
            FILL_BRIGHT:  pix = pix_type'($urandom_range(240, 255));
            FILL_DIM:     pix = pix_type'($urandom_range(0, 15));
            default:      pix = pix_type'($urandom);
         endcase
         fs = (i == 0 && start_frame) || (noise && $urandom_range(0, 49) == 0);
         if (fs) frame_width = eff;
         send_pixel(pix, fs);
         if (in_idle_on) pause_input(idle_len());
      end
      req_valid <= 1'b0;
   endtask

   // Result side: random stalls, plus a long hold-off when asked for
   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         n = idle_len();
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
            rsp_stall <= 1'b0;
         end else if (out_idle_on && n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int            k;
      int            w;
      int            s;
      int            eff;
      int            count;
      int            pick;
      int            random_sent;
      bit            start_frame;
      fill_mode_type mode;
      pix_type       pix;

      req_valid       = 1'b0;
      req_raw_pixel   = '0;
      req_frame_start = 1'b0;
      csr_write_en    = 1'b0;
      csr_index       = CSR_IMAGE_WIDTH;
      csr_wdata       = '0;
      reset           = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: saturation at shift 0, zeros, walking ones, restart in mid-row
      program_setting(8, 0);
      for (k = 0; k < 24; k++) begin
         case (k % 3)
            0:       pix = '1;
            1:       pix = '0;
            default: pix = pix_type'(1) << (k % PIX_W);
         endcase
         send_pixel(pix, k == 0 || k == 19);
      end
      req_valid <= 1'b0;
      frame_width = 8;

      // Random phases, each with its own width, shift, content and idling
      random_sent = 0;
      k = 0;
      while (random_sent < RANDOM_PIXELS) begin
         in_idle_on  = ($urandom_range(0, 3) != 0);
         out_idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         mode = (pick < 6) ? FILL_RANDOM : fill_mode_type'($urandom_range(1, 3));
         case (k)
            0: begin
               w = 8;
               s = SHIFT_ALL;
            end
            1: begin
               w = $urandom_range(9, 40);
               s = 0;
            end
            2: begin
               // width zero clamps to one column
               w = 0;
               s = $urandom_range(0, SHIFT_ALL);
            end
            3: begin
               // widest setting clamps to MAX_WIDTH
               w = WIDTH_ALL;
               s = 8;
            end
            default: begin
               pick = $urandom_range(0, 99);
               if (pick < 70)      w = $urandom_range(8, 40);
               else if (pick < 80) w = $urandom_range(1, 7);
               else if (pick < 88) w = $urandom_range(41, 200);
               else if (pick < 94) w = 0;
               else                w = $urandom_range(MAX_WIDTH + 1, WIDTH_ALL);
               s = $urandom_range(0, SHIFT_ALL);
            end
         endcase
         eff = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
         count = $urandom_range(0, 6) * eff + $urandom_range(1, eff);
         if (count > PHASE_CAP) count = PHASE_CAP;

         program_setting(w, s);
         // a wider row needs a fresh frame so no unwritten line-store column is read
         start_frame = (eff > frame_width) || ($urandom_range(0, 1) == 0);
         if (start_frame || eff < frame_width) frame_width = eff;

         // now and then stall the result side for long while the input runs flat out
         if (k % 4 == 1) begin
            hold_output = 1'b1;
            in_idle_on  = 1'b0;
            if (count < 100) count = 100;
         end

         run_phase(count, eff, mode, start_frame, k > 3);
         random_sent += count;
         k++;
      end

      wait_drained();
      if (failures == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Give up on a hung run
   initial begin : watchdog
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
